[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/tpf_pkg.sv]
// Shared constants, types and microcode ROM of the telemetry packet framer.
`default_nettype none

package tpf_pkg;

  // Sizes
  localparam int FIFO_DEPTH   = 1024;
  localparam int FRAME_LENGTH = 39;
  localparam int HDR_LEN      = 6;
  localparam int PAY_LEN      = FRAME_LENGTH - HDR_LEN;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int REP_MAX      = (PAY_LEN > 3) ? PAY_LEN : 3;
  localparam int REP_W        = $clog2(REP_MAX);
  localparam int SEQ_W        = 14;
  localparam int NUM_CTR      = 3;
  localparam int PC_W         = 3;

  // Configuration register indexes and reset values
  localparam logic CFG_SYNC = 1'b0;
  localparam logic CFG_TYPE = 1'b1;
  localparam logic [7:0] SYNC_RESET = 8'h50;
  localparam logic [7:0] TYPE_RESET = 8'h0C;
  localparam logic [SEQ_W-1:0] SEQ_MAX = 14'h3FFF;

  // Request codes
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // Source that shares the IMU counter
  localparam logic [1:0] SRC_SHARED = 2'd3;
  localparam logic [1:0] SRC_IMU    = 2'd0;

  // Program steps
  localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] STEP_SYNC   = 3'd1;
  localparam logic [PC_W-1:0] STEP_TYPE   = 3'd2;
  localparam logic [PC_W-1:0] STEP_SEQ_HI = 3'd3;
  localparam logic [PC_W-1:0] STEP_SEQ_LO = 3'd4;
  localparam logic [PC_W-1:0] STEP_PAY    = 3'd5;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_SYNC,
    SEL_TYPE,
    SEL_SEQ_HI,
    SEL_SEQ_LO,
    SEL_PAYLOAD
  } byte_sel_e;

  typedef enum logic {
    CND_REQ,   // hold until a frame request arrives, then jump
    CND_DONE   // jump once all repeats of this step are emitted
  } jmp_cond_e;

  typedef struct packed {
    byte_sel_e             sel;
    jmp_cond_e             cond;
    logic                  last;
    logic [REP_W-1:0]      rep_m1;
    logic [PC_W-1:0]       target;
  } ctrl_word_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic      idle;
    logic      emit;
    byte_sel_e sel;
    logic      last;
  } seq_ctrl_t;

  // Microcode ROM
  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{sel: SEL_NONE, cond: CND_REQ, last: 1'b0, rep_m1: '0, target: STEP_SYNC};
    unique case (pc)
      STEP_IDLE:   w = '{sel: SEL_NONE, cond: CND_REQ, last: 1'b0,
                         rep_m1: '0, target: STEP_SYNC};
      STEP_SYNC:   w = '{sel: SEL_SYNC, cond: CND_DONE, last: 1'b0,
                         rep_m1: REP_W'(2), target: STEP_TYPE};
      STEP_TYPE:   w = '{sel: SEL_TYPE, cond: CND_DONE, last: 1'b0,
                         rep_m1: '0, target: STEP_SEQ_HI};
      STEP_SEQ_HI: w = '{sel: SEL_SEQ_HI, cond: CND_DONE, last: 1'b0,
                         rep_m1: '0, target: STEP_SEQ_LO};
      STEP_SEQ_LO: w = '{sel: SEL_SEQ_LO, cond: CND_DONE, last: 1'b0,
                         rep_m1: '0, target: STEP_PAY};
      STEP_PAY:    w = '{sel: SEL_PAYLOAD, cond: CND_DONE, last: 1'b1,
                         rep_m1: REP_W'(PAY_LEN - 1), target: STEP_IDLE};
      default:     w = '{sel: SEL_NONE, cond: CND_REQ, last: 1'b0,
                         rep_m1: '0, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/tpf_seq.sv]
// Microcoded sequencer: step counter, repeat counter and ROM decode.
`default_nettype none

module tpf_seq
  import tpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      go_i,
  input  wire logic      emit_ok_i,
  output seq_ctrl_t      ctrl_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [REP_W-1:0] rep_q, rep_d;
  ctrl_word_t       word;
  logic             rep_done;

  // Decode the current step
  always_comb begin
    word        = rom_word(pc_q);
    rep_done    = (rep_q == word.rep_m1);
    ctrl_o.idle = (word.cond == CND_REQ);
    ctrl_o.emit = (word.sel != SEL_NONE);
    ctrl_o.sel  = word.sel;
    ctrl_o.last = word.last & rep_done;
  end

  // Advance the step and repeat counters
  always_comb begin
    pc_d  = pc_q;
    rep_d = rep_q;
    unique case (word.cond)
      CND_REQ: begin
        if (go_i) begin
          pc_d  = word.target;
          rep_d = '0;
        end
      end
      CND_DONE: begin
        if (emit_ok_i) begin
          if (rep_done) begin
            pc_d  = word.target;
            rep_d = '0;
          end else begin
            rep_d = rep_q + REP_W'(1);
          end
        end
      end
      default: begin
        pc_d  = STEP_IDLE;
        rep_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= STEP_IDLE;
      rep_q <= '0;
    end else begin
      pc_q  <= pc_d;
      rep_q <= rep_d;
    end
  end

endmodule

`default_nettype wire

[hdl/tpf_fifo.sv]
// Payload byte FIFO with a prefetched head read from block memory.
`default_nettype none

module tpf_fifo
  import tpf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      head_o
);

  logic [7:0]         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic [7:0]         rd_data_q;
  logic               full, do_push, do_pop;

  function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
  endfunction

  // Drop pushes into a full FIFO; ignore pops of an empty one
  always_comb begin
    full     = (cnt_q == FIFO_CW'(FIFO_DEPTH));
    empty_o  = (cnt_q == '0);
    do_push  = push_i & ~full;
    do_pop   = pop_i & ~empty_o;
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
    head_o = rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write port and head prefetch at the next read pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    rd_data_q <= mem[rd_ptr_d];
  end

endmodule

`default_nettype wire

[hdl/telemetry_packet_framer.sv]
// Top level of the telemetry packet framer: config, counters and byte datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type_i, payload_byte_i, source_id_i
//  out     | output    | out_valid_o / out_stall_i | frame_byte_o, last_byte_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A frame request is accepted while the sequencer is idle; the sequencer then loads
// FRAME_LENGTH bytes, one per cycle unless the output stalls, into the output register.
// Output stalls freeze the sequencer; the input stalls from the accepted request
// until the last byte is loaded. The FIFO head is prefetched from the simple
// dual-port payload memory. Reset is asynchronous; no memory clearing pass.
`default_nettype none

module telemetry_packet_framer
  import tpf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic [1:0] source_id_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  seq_ctrl_t         ctrl;
  logic              in_acc, go, push, emit_ok, pop;
  logic              fifo_empty;
  logic [7:0]        fifo_head;
  logic [7:0]        sync_q, type_q;
  logic [SEQ_W-1:0]  seq_cnt_q [NUM_CTR];
  logic [1:0]        ctr_idx;
  logic [15:0]       seq_word_q;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic [7:0]        byte_mux;

  // Input handshake
  always_comb begin
    in_stall_o = ~ctrl.idle;
    in_acc     = in_valid_i & ctrl.idle;
    go         = in_acc & (req_type_i == REQ_FRAME);
    push       = in_acc & (req_type_i == REQ_PUSH);
    emit_ok    = ctrl.emit & (~out_valid_q | ~out_stall_i);
    pop        = emit_ok & (ctrl.sel == SEL_PAYLOAD);
    ctr_idx    = (source_id_i == SRC_SHARED) ? SRC_IMU : source_id_i;
  end

  tpf_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .emit_ok_i (emit_ok),
    .ctrl_o    (ctrl)
  );

  tpf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (payload_byte_i),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .head_o      (fifo_head)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      type_q <= TYPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC: sync_q <= cfg_data_i;
        CFG_TYPE: type_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Latch the header word and advance the source counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CTR; i++) begin
        seq_cnt_q[i] <= '0;
      end
    end else if (go) begin
      seq_cnt_q[ctr_idx] <= (seq_cnt_q[ctr_idx] == SEQ_MAX) ? '0
                          : seq_cnt_q[ctr_idx] + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      seq_word_q <= {source_id_i, seq_cnt_q[ctr_idx]};
    end
  end

  // Select the byte of the current step
  always_comb begin
    unique case (ctrl.sel)
      SEL_SYNC:    byte_mux = sync_q;
      SEL_TYPE:    byte_mux = type_q;
      SEL_SEQ_HI:  byte_mux = seq_word_q[15:8];
      SEL_SEQ_LO:  byte_mux = seq_word_q[7:0];
      SEL_PAYLOAD: byte_mux = fifo_empty ? 8'h00 : fifo_head;
      default:     byte_mux = 8'h00;
    endcase
  end

  // Output register: load on emit, drop valid when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      out_byte_q <= byte_mux;
      out_last_q <= ctrl.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

endmodule

`default_nettype wire

[hdl/tpf_checker.sv]
// Port-level checker for the telemetry packet framer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tpf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       req_type_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] frame_byte_o,
  input wire logic       last_byte_o
);

  // Hold a stalled output beat
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(frame_byte_o) && $stable(last_byte_o))

  // Stall input right after a frame request is taken
  `ASSERT_NEXT(a_frame_stalls_in, in_valid_i && !in_stall_o && req_type_i, in_stall_o)

  // Keep input stalled while a frame is mid-flight
  `ASSERT_SAME(a_mid_frame_stall, out_valid_o && !last_byte_o, in_stall_o)

  // Never show two frame ends back to back
  `ASSERT_NEXT(a_no_double_last, out_valid_o && !out_stall_i && last_byte_o, !(out_valid_o && last_byte_o))

endmodule

bind telemetry_packet_framer tpf_checker u_tpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

`default_nettype wire

[sim/tb_telemetry_packet_framer.sv]
// Self-checking testbench for the telemetry packet framer: push/frame traffic, checked per beat.
`timescale 1ns / 1ps

module tb_telemetry_packet_framer;
  import tpf_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SHOW_LIMIT    = 100;

  // Source codes without a name in the package
  localparam logic [1:0] SRC_RAD  = 2'd1;
  localparam logic [1:0] SRC_POLY = 2'd2;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic [1:0] src;
  } framer_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // DUT ports; the inputs are known from time zero
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic       req_type_i     = REQ_PUSH;
  logic [7:0] payload_byte_i = 8'h00;
  logic [1:0] source_id_i    = SRC_IMU;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_idx_i      = CFG_SYNC;
  logic [7:0] cfg_data_i     = 8'h00;

  // Request stream and expected frame beats
  framer_req_t pending_reqs[$];
  frame_beat_t framed_beats[$];
  framer_req_t next_req;
  frame_beat_t want_beat;

  // Shadow state of the framer
  logic [7:0]       payload_mirror [FIFO_DEPTH];
  int unsigned      mirror_rd;
  int unsigned      mirror_wr;
  int unsigned      mirror_fill;
  logic [SEQ_W-1:0] seq_count [NUM_CTR];
  logic [7:0]       sync_val = SYNC_RESET;
  logic [7:0]       type_val = TYPE_RESET;

  // Traffic shaping knobs and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  bit          hold_for_drain = 1'b0;
  int unsigned queued_reqs       = 0;
  int unsigned accepted_reqs     = 0;
  int unsigned frames_checked    = 0;
  int unsigned beats_checked     = 0;
  int unsigned bytes_dropped     = 0;
  int unsigned seq_wraps         = 0;
  int unsigned mismatches        = 0;
  int unsigned cycle_count       = 0;

  telemetry_packet_framer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .payload_byte_i (payload_byte_i),
    .source_id_i    (source_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .last_byte_o    (last_byte_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    mirror_rd   = 0;
    mirror_wr   = 0;
    mirror_fill = 0;
    for (int i = 0; i < NUM_CTR; i++) seq_count[i] = '0;
  end

  // Append one payload byte to the shadow buffer; drop it when full
  task automatic stash_payload(input logic [7:0] b);
    if (mirror_fill >= FIFO_DEPTH) begin
      bytes_dropped++;
    end else begin
      payload_mirror[mirror_wr] = b;
      mirror_wr = (mirror_wr + 1) % FIFO_DEPTH;
      mirror_fill++;
    end
  endtask

  // Work out the beats of one frame and advance the source's sequence count
  task automatic build_frame(input logic [1:0] src);
    int unsigned ctr;
    int          k;
    logic [15:0] word;
    frame_beat_t b;
    ctr  = (src == SRC_SHARED) ? SRC_IMU : src;
    word = {src, seq_count[ctr]};
    if (seq_count[ctr] == SEQ_MAX) begin
      seq_count[ctr] = '0;
      seq_wraps++;
    end else begin
      seq_count[ctr] = seq_count[ctr] + 1'b1;
    end
    for (k = 0; k < FRAME_LENGTH; k++) begin
      b.last = (k == FRAME_LENGTH - 1);
      if (k < 3) begin
        b.data = sync_val;
      end else if (k == 3) begin
        b.data = type_val;
      end else if (k == 4) begin
        b.data = word[15:8];
      end else if (k == 5) begin
        b.data = word[7:0];
      end else if (mirror_fill == 0) begin
        b.data = 8'h00;
      end else begin
        b.data = payload_mirror[mirror_rd];
        mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
        mirror_fill--;
      end
      framed_beats.push_back(b);
    end
  endtask

  task automatic queue_push(input logic [7:0] b);
    framer_req_t r;
    r.req  = REQ_PUSH;
    r.data = b;
    r.src  = 2'($urandom_range(3));
    pending_reqs.push_back(r);
    queued_reqs++;
  endtask

  task automatic queue_frame(input logic [1:0] src);
    framer_req_t r;
    r.req  = REQ_FRAME;
    r.data = 8'($urandom_range(255));
    r.src  = src;
    pending_reqs.push_back(r);
    queued_reqs++;
  endtask

  // Runs of pushes, each closed by a frame from a random source
  task automatic queue_random_run(input int unsigned n_items);
    int unsigned made;
    int unsigned burst;
    int unsigned j;
    made = 0;
    while (made < n_items) begin
      burst = ($urandom_range(1) == 0) ? $urandom_range(5) : $urandom_range(45);
      for (j = 0; j < burst; j++) queue_push(8'($urandom_range(255)));
      queue_frame(2'($urandom_range(3)));
      made += burst + 1;
    end
  endtask

  // Hold until every request is taken and every beat has come, then let pushes settle
  task automatic wait_quiet();
    while (accepted_reqs != queued_reqs || framed_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SYNC) sync_val = value;
    else type_val = value;
  endtask

  // Request driver: predict on each accepted beat, then present the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        accepted_reqs++;
        if (req_type_i == REQ_PUSH) stash_payload(payload_byte_i);
        else build_frame(source_id_i);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
          send_gap = $urandom_range(19, 1);
        if (send_idle_pct != 0 && $urandom_range(49) == 0) hold_for_drain = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (hold_for_drain && framed_beats.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          hold_for_drain = 1'b0;
          next_req = pending_reqs.pop_front();
          in_valid_i     <= 1'b1;
          req_type_i     <= next_req.req;
          payload_byte_i <= next_req.data;
          source_id_i    <= next_req.src;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: check each accepted beat, and stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (framed_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: unexpected beat, frame_byte %02h last_byte %0b",
                     $time, frame_byte_o, last_byte_o);
        end else begin
          want_beat = framed_beats.pop_front();
          beats_checked++;
          if (want_beat.last) frames_checked++;
          if (frame_byte_o !== want_beat.data) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("%0t: frame_byte expected %02h, actual %02h",
                       $time, want_beat.data, frame_byte_o);
          end
          if (last_byte_o !== want_beat.last) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("%0t: last_byte expected %0b, actual %0b",
                       $time, want_beat.last, last_byte_o);
          end
        end
        if (mismatches == SHOW_LIMIT + 1)
          $display("%0t: further mismatches counted only", $time);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats still due",
               $time, cycle_count, framed_beats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus phases
  initial begin
    int unsigned i;
    send_idle_pct = 20;
    stall_pct     = 5;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values, empty and short buffer, every source
    queue_frame(SRC_IMU);
    queue_push(8'h00);
    queue_push(8'hFF);
    queue_push(8'hA5);
    queue_push(8'h5A);
    queue_frame(SRC_RAD);
    queue_frame(SRC_POLY);
    queue_push(8'h01);
    queue_push(8'h80);
    queue_frame(SRC_SHARED);
    queue_frame(SRC_IMU);
    queue_frame(SRC_RAD);
    wait_quiet();

    // Buffer more than two frames of payload, then drain it completely
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_TYPE, 8'hFF);
    send_idle_pct = 10;
    stall_pct     = 5;
    for (i = 0; i < 2 * PAY_LEN + 4; i++) queue_push(8'($urandom_range(255)));
    for (i = 0; i < 3; i++) queue_frame(2'($urandom_range(3)));
    wait_quiet();

    // Random traffic, moderate idling
    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_TYPE, 8'h00);
    send_idle_pct = 25;
    stall_pct     = 8;
    queue_random_run(110);
    wait_quiet();

    // Random traffic, heavy idling on both sides
    write_reg(CFG_SYNC, 8'($urandom_range(255)));
    write_reg(CFG_TYPE, 8'($urandom_range(255)));
    send_idle_pct = 60;
    stall_pct     = 20;
    queue_random_run(110);
    wait_quiet();

    // Full rate, no idling on either side
    write_reg(CFG_TYPE, 8'($urandom_range(255)));
    write_reg(CFG_SYNC, 8'($urandom_range(255)));
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random_run(60);
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d frames (%0d beats) from %0d requests over %0d cycles.",
             frames_checked, beats_checked, accepted_reqs, cycle_count);
    $display("Payload bytes dropped on a full buffer: %0d; sequence count wraps: %0d.",
             bytes_dropped, seq_wraps);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/tpf_pkg.sv
hdl/tpf_seq.sv
hdl/tpf_fifo.sv
hdl/telemetry_packet_framer.sv
hdl/tpf_checker.sv
sim/tb_telemetry_packet_framer.sv
